// ===== sv/luhn_pkg.sv =====
// Shared types and constants for the Luhn card classifier.
`timescale 1ns / 1ps
`default_nettype none

package luhn_pkg;

  // Card number width and the decimal digits it can reach.
  localparam int BIN_W      = 63;
  localparam int BCD_DIGITS = 19;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int DCNT_W     = 5;

  // Default for the number of digits examined.
  localparam int MAX_DIGITS_DEF = 19;

  // Lengths that the card brands use.
  localparam int AMEX_LEN       = 15;
  localparam int MC_LEN         = 16;
  localparam int VISA_SHORT_LEN = 13;
  localparam int VISA_LONG_LEN  = 16;
  localparam int RADIX          = 10;

  typedef enum logic [1:0] {
    VERDICT_INVALID    = 2'd0,
    VERDICT_AMEX       = 2'd1,
    VERDICT_MASTERCARD = 2'd2,
    VERDICT_VISA       = 2'd3
  } verdict_t;

  typedef struct packed {
    verdict_t            verdict;
    logic                checksum_ok;
    logic [DCNT_W-1:0]   digit_count;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/luhn_if.sv =====
// Valid/ready channel interfaces for card words and result words.
`timescale 1ns / 1ps
`default_nettype none

interface luhn_in_if;
  logic                        valid;
  logic                        ready;
  logic [luhn_pkg::BIN_W-1:0]  card_number;

  modport source (output valid, output card_number, input ready);
  modport sink   (input valid, input card_number, output ready);
endinterface

interface luhn_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   verdict;
  logic                         checksum_ok;
  logic [luhn_pkg::DCNT_W-1:0]  digit_count;

  modport source (output valid, output verdict, output checksum_ok, output digit_count,
                  input ready);
  modport sink   (input valid, input verdict, input checksum_ok, input digit_count,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/luhn_bcd_conv.sv =====
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module luhn_bcd_conv (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [luhn_pkg::BIN_W-1:0]    number,
  output logic                               done,
  output logic [luhn_pkg::BCD_W-1:0]         bcd
);

  localparam int CNT_W = $clog2(luhn_pkg::BIN_W);

  logic [luhn_pkg::BIN_W-1:0] bits_r, bits_nxt;
  logic [luhn_pkg::BCD_W-1:0] bcd_r, bcd_nxt;
  logic [luhn_pkg::BCD_W-1:0] adj;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;

  // Each BCD digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < luhn_pkg::BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? (bcd_r[4*i +: 4] + 4'd3)
                                                 : bcd_r[4*i +: 4];
    end
  end

  // Load on start, then shift the binary word in, most significant bit first.
  always_comb begin
    bits_nxt = bits_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bits_nxt = number;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt  = {adj[luhn_pkg::BCD_W-2:0], bits_r[luhn_pkg::BIN_W-1]};
      bits_nxt = {bits_r[luhn_pkg::BIN_W-2:0], 1'b0};
      cnt_nxt  = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(luhn_pkg::BIN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r <= bits_nxt;
    bcd_r  <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

`default_nettype wire

// ===== sv/luhn_scan.sv =====
// Digit scanner: Luhn sum, digit count and leading digits, then the verdict.
`timescale 1ns / 1ps
`default_nettype none

module luhn_scan #(
  parameter int MAX_DIGITS = luhn_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [luhn_pkg::BCD_W-1:0]    bcd,
  output logic                               done,
  output luhn_pkg::res_t                     res
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  logic [luhn_pkg::BCD_W-1:0] sh_r, sh_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [3:0]                 sum_r, sum_nxt;
  logic [3:0]                 prev_r, prev_nxt;
  logic [3:0]                 lead_r, lead_nxt;
  logic [3:0]                 second_r, second_nxt;
  logic                       busy_r, busy_nxt;
  logic                       fin_r, fin_nxt;
  logic                       done_r;
  luhn_pkg::res_t             res_r, res_nxt;

  logic [3:0] dig;
  logic [4:0] dbl;
  logic [4:0] term;
  logic [4:0] acc;
  logic       ovf;
  logic       ok;

  // Weight of the current digit: doubled at odd positions, folded above nine.
  always_comb begin
    dig  = sh_r[3:0];
    dbl  = {dig, 1'b0};
    if (idx_r[0]) begin
      term = (dbl > 5'd9) ? (dbl - 5'd9) : dbl;
    end else begin
      term = {1'b0, dig};
    end
    acc = {1'b0, sum_r} + term;
  end

  // One digit per cycle from the least significant end.
  always_comb begin
    sh_nxt     = sh_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    prev_nxt   = prev_r;
    lead_nxt   = lead_r;
    second_nxt = second_r;
    busy_nxt   = busy_r;
    fin_nxt    = 1'b0;
    if (start) begin
      sh_nxt     = bcd;
      idx_nxt    = '0;
      count_nxt  = '0;
      sum_nxt    = '0;
      prev_nxt   = '0;
      lead_nxt   = '0;
      second_nxt = '0;
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      sh_nxt  = {4'd0, sh_r[luhn_pkg::BCD_W-1:4]};
      sum_nxt = (acc >= 5'(luhn_pkg::RADIX)) ? 4'(acc - 5'(luhn_pkg::RADIX)) : acc[3:0];
      if (dig != 4'd0) begin
        count_nxt  = CNT_W'(idx_r) + CNT_W'(1);
        lead_nxt   = dig;
        second_nxt = prev_r;
      end
      prev_nxt = dig;
      idx_nxt  = idx_r + IDX_W'(1);
      if (idx_r == IDX_W'(MAX_DIGITS - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  // Classification from length, leading digits and checksum.
  always_comb begin
    ovf = (sh_r != '0);
    ok  = (sum_r == 4'd0);
    res_nxt.verdict     = luhn_pkg::VERDICT_INVALID;
    res_nxt.checksum_ok = ok;
    res_nxt.digit_count = luhn_pkg::DCNT_W'(count_r);
    if (ovf) begin
      res_nxt.checksum_ok = 1'b0;
      res_nxt.digit_count = luhn_pkg::DCNT_W'(MAX_DIGITS);
    end else if (ok && count_r != '0) begin
      priority if (count_r == CNT_W'(luhn_pkg::AMEX_LEN) && lead_r == 4'd3 &&
                   (second_r == 4'd4 || second_r == 4'd7)) begin
        res_nxt.verdict = luhn_pkg::VERDICT_AMEX;
      end else if (count_r == CNT_W'(luhn_pkg::MC_LEN) && lead_r == 4'd5 &&
                   second_r >= 4'd1 && second_r <= 4'd5) begin
        res_nxt.verdict = luhn_pkg::VERDICT_MASTERCARD;
      end else if ((count_r == CNT_W'(luhn_pkg::VISA_SHORT_LEN) ||
                    count_r == CNT_W'(luhn_pkg::VISA_LONG_LEN)) && lead_r == 4'd4) begin
        res_nxt.verdict = luhn_pkg::VERDICT_VISA;
      end else begin
        res_nxt.verdict = luhn_pkg::VERDICT_INVALID;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= fin_r;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r     <= sh_nxt;
    count_r  <= count_nxt;
    sum_r    <= sum_nxt;
    prev_r   <= prev_nxt;
    lead_r   <= lead_nxt;
    second_r <= second_nxt;
    if (fin_r) begin
      res_r <= res_nxt;
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

`default_nettype wire

// ===== sv/luhn_card_classifier.sv =====
// Top level of the Luhn card classifier: sequencing and the result register.
//
// Usage: a card number word enters on in_ch (valid/ready); one result word
// leaves on out_ch with the verdict, the Luhn checksum flag and the count of
// decimal digits. Every card word gives exactly one result word.
// The number is first converted to decimal by a shift-and-add-3 converter,
// one binary bit per cycle, then MAX_DIGITS decimal digits are scanned one
// per cycle and classified, and the scanner registers the result before it
// goes to the output register. One word is in work at a time.
// in_ch.ready is high whenever the block is idle, also while a finished word
// still waits in the output register; a stalled receiver only holds the next
// result back once that one is complete.
// Reset (rst_n low, synchronous) drops any word in work and clears
// out_ch.valid.
`timescale 1ns / 1ps
`default_nettype none

module luhn_card_classifier #(
  parameter int MAX_DIGITS = luhn_pkg::MAX_DIGITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  luhn_in_if.sink     in_ch,
  luhn_out_if.source  out_ch
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  state_t                      state_r, state_nxt;
  logic                        out_valid_r, out_valid_nxt;
  luhn_pkg::res_t              out_r;
  luhn_pkg::res_t              scan_res;
  logic [luhn_pkg::BCD_W-1:0]  bcd;
  logic                        in_take;
  logic                        out_free;
  logic                        load;
  logic                        conv_done;
  logic                        scan_done;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  luhn_bcd_conv u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_take),
    .number (in_ch.card_number),
    .done   (conv_done),
    .bcd    (bcd)
  );

  luhn_scan #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_done),
    .bcd   (bcd),
    .done  (scan_done),
    .res   (scan_res)
  );

  // Sequencer: convert, scan, then hand the word to the output register.
  always_comb begin
    state_nxt = state_r;
    load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (conv_done) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (out_free) begin
            load      = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= scan_res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.verdict     = out_r.verdict;
  assign out_ch.checksum_ok = out_r.checksum_ok;
  assign out_ch.digit_count = out_r.digit_count;

`ifndef SYNTHESIS
  a_conv_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    conv_done |-> state_r == ST_CONV)
    else $error("converter finished outside the conversion phase");

  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |-> state_r == ST_SCAN)
    else $error("scanner finished outside the scan phase");

  a_take_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r == ST_CONV)
    else $error("accepted word did not start a conversion");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.digit_count <= MAX_DIGITS)
    else $error("digit count above the examined maximum");

  a_verdict_needs_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.verdict != luhn_pkg::VERDICT_INVALID) |-> out_r.checksum_ok)
    else $error("brand verdict given without a passing checksum");
`endif

endmodule

`default_nettype wire
